// File: sv/hopscotch_hash_table_unit_defines.svh
`ifndef HOPSCOTCH_HASH_TABLE_UNIT_DEFINES_SVH
`define HOPSCOTCH_HASH_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define HHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define HHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/hht_pkg.sv
`default_nettype none

package hht_pkg;

  localparam int EXP         = 8;
  localparam int HASH_W      = 32;
  localparam int VAL_W       = 32;
  localparam int ID_HOP_BITS = 6;
  localparam int ID_W        = 14;
  localparam int NHOME       = 1 << EXP;
  localparam int NBKT        = NHOME + EXP - 1;
  localparam int BA_W        = $clog2(NBKT);
  localparam int FRAG_W      = HASH_W - EXP;
  localparam int OFF_W       = $clog2(EXP);
  localparam int LB_W        = $clog2(EXP + 1);
  localparam int CNT_W       = $clog2(NBKT + 1);

  typedef enum logic [1:0] {
    KIND_INS  = 2'd0,
    KIND_SRCH = 2'd1,
    KIND_DEL  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_MISS    = 2'd1,
    STAT_NO_ROOM = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOME,
    ST_SRCH,
    ST_IDCHK,
    ST_PROBE,
    ST_SCAN,
    ST_MVW1,
    ST_MVW2,
    ST_INSW
  } st_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [HASH_W-1:0] hashcode;
    logic [VAL_W-1:0]  value;
    logic              by_id;
    logic [ID_W-1:0]   pack_id;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] found_value;
    logic [ID_W-1:0]  result_id;
    logic [CNT_W-1:0] occupancy;
  } out_t;

  // Slot word: valid flag, hash fragment and value
  typedef struct packed {
    logic              vld;
    logic [FRAG_W-1:0] frag;
    logic [VAL_W-1:0]  val;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Position of the lowest set bit, EXP when none is set
  function automatic logic [LB_W-1:0] low_bit(logic [EXP-1:0] m);
    logic [LB_W-1:0] r;
    r = LB_W'(EXP);
    for (int k = EXP - 1; k >= 0; k--) begin
      if (m[k]) r = LB_W'(k);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/hht_ram.sv
`default_nettype none

module hht_ram #(
  parameter int  W  = 8,
  parameter int  D  = 4,
  localparam int AW = $clog2(D)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/hopscotch_hash_table_unit.sv
// Channel   | Signals              | Transfer
// ----------+----------------------+-------------------------------------
// request   | start_i, req_i       | start_i high while busy_o is low
// response  | done_o, rsp_o        | done_o high for one cycle, no stall
//
// One operation at a time. Search and delete by hashcode read the home hop
// map, then read one slot per neighbour tried; delete by id reads the hop
// map and the slot together, and a rejected id or an unused kind is answered
// straight from idle. Insert probes one slot per read, then makes hopscotch
// swaps (scan, move, free); the probe and swap loops run over the two
// one-read, one-write memories. After reset a clearing pass over all 263
// buckets holds busy_o high. The response is registered and cannot be stalled.
`default_nettype none

`include "hopscotch_hash_table_unit_defines.svh"

module hopscotch_hash_table_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire hht_pkg::in_t req_i,
  output logic              busy_o,
  output logic              done_o,
  output hht_pkg::out_t     rsp_o
);

  import hht_pkg::*;

  st_e               st_q, st_d;
  logic [1:0]        kind_q, kind_d;
  logic [EXP-1:0]    home_q, home_d;
  logic [FRAG_W-1:0] frag_q, frag_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [OFF_W-1:0]  i_q, i_d;
  logic [EXP-1:0]    hm_q, hm_d;
  logic [BA_W-1:0]   b_q, b_d;
  logic [BA_W-1:0]   s_q, s_d;
  logic [BA_W-1:0]   src_q, src_d;
  logic [BA_W-1:0]   clr_q, clr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  out_t              rsp_q, rsp_d;
  logic              done_q, done_d;

  // Memory ports
  logic            a_we, b_we;
  logic [BA_W-1:0] a_wa, a_ra, b_wa, b_ra;
  logic [EXP-1:0]  a_wd, a_rd;
  slot_t           b_wd, b_rd;
  logic [SLOT_W-1:0] b_rd_raw;

  // Hop maps
  hht_ram #(.W(EXP), .D(NBKT)) u_hop_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_wa),
    .wdata_i (a_wd),
    .raddr_i (a_ra),
    .rdata_o (a_rd)
  );

  // Slot words
  hht_ram #(.W(SLOT_W), .D(NBKT)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_wa),
    .wdata_i (b_wd),
    .raddr_i (b_ra),
    .rdata_o (b_rd_raw)
  );

  assign b_rd = slot_t'(b_rd_raw);

  logic              accept;
  logic [ID_W-ID_HOP_BITS-1:0] id_home;
  logic [ID_HOP_BITS-1:0]      id_off;
  logic [BA_W-1:0]   home_ba;
  logic [BA_W-1:0]   cur_bkt;
  logic              hit;
  logic [LB_W-1:0]   lb;
  logic [OFF_W-1:0]  hop_dist;
  logic [OFF_W-1:0]  ins_off;

  assign accept  = start_i && !busy_o;
  assign id_home = req_i.pack_id[ID_W-1:ID_HOP_BITS];
  assign id_off  = req_i.pack_id[ID_HOP_BITS-1:0];
  assign home_ba = BA_W'(home_q);
  assign cur_bkt = home_ba + BA_W'(i_q);
  assign hit     = hm_q[i_q] && b_rd.vld && (b_rd.frag == frag_q)
                   && ((kind_q != KIND_DEL) || (b_rd.val == val_q));
  assign lb      = low_bit(a_rd);
  assign hop_dist = OFF_W'(b_q - s_q);
  assign ins_off = OFF_W'(b_q - home_ba);

  // Control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_CLEAR;
      clr_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      clr_q  <= clr_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Operation context, no reset needed
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    home_q <= home_d;
    frag_q <= frag_d;
    val_q  <= val_d;
    i_q    <= i_d;
    hm_q   <= hm_d;
    b_q    <= b_d;
    s_q    <= s_d;
    src_q  <= src_d;
    rsp_q  <= rsp_d;
  end

  // Sequencer: next state, memory accesses and result
  always_comb begin
    st_d   = st_q;
    kind_d = kind_q;
    home_d = home_q;
    frag_d = frag_q;
    val_d  = val_q;
    i_d    = i_q;
    hm_d   = hm_q;
    b_d    = b_q;
    s_d    = s_q;
    src_d  = src_q;
    clr_d  = clr_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rsp_d  = rsp_q;
    a_we   = 1'b0;
    a_wa   = '0;
    a_wd   = '0;
    a_ra   = '0;
    b_we   = 1'b0;
    b_wa   = '0;
    b_wd   = '0;
    b_ra   = '0;

    case (st_q)
      ST_CLEAR: begin
        // Sweep both memories to empty
        a_we  = 1'b1;
        a_wa  = clr_q;
        b_we  = 1'b1;
        b_wa  = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == BA_W'(NBKT - 1)) st_d = ST_IDLE;
      end

      ST_IDLE: begin
        if (accept) begin
          kind_d = req_i.kind;
          val_d  = req_i.value;
          home_d = req_i.hashcode[HASH_W-1:FRAG_W];
          frag_d = req_i.hashcode[FRAG_W-1:0];
          rsp_d  = '{status: STAT_MISS, found_value: '0, result_id: '0,
                     occupancy: cnt_q};
          case (req_i.kind)
            KIND_INS: begin
              b_d  = BA_W'(req_i.hashcode[HASH_W-1:FRAG_W]);
              b_ra = BA_W'(req_i.hashcode[HASH_W-1:FRAG_W]);
              st_d = ST_PROBE;
            end
            KIND_SRCH: begin
              a_ra = BA_W'(req_i.hashcode[HASH_W-1:FRAG_W]);
              st_d = ST_HOME;
            end
            KIND_DEL: begin
              if (!req_i.by_id) begin
                a_ra = BA_W'(req_i.hashcode[HASH_W-1:FRAG_W]);
                st_d = ST_HOME;
              end else if ((int'(id_home) < NHOME) && (int'(id_off) < EXP)) begin
                home_d = EXP'(id_home);
                i_d    = id_off[OFF_W-1:0];
                a_ra   = BA_W'(id_home);
                b_ra   = BA_W'(id_home) + BA_W'(id_off);
                st_d   = ST_IDCHK;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_HOME: begin
        // Hold the home hop map, start the neighbour scan
        hm_d = a_rd;
        i_d  = '0;
        b_ra = home_ba;
        st_d = ST_SRCH;
      end

      ST_SRCH: begin
        if (hit) begin
          rsp_d.status    = STAT_OK;
          rsp_d.result_id = ID_W'({home_q, ID_HOP_BITS'(i_q)});
          if (kind_q == KIND_DEL) begin
            a_we = 1'b1;
            a_wa = home_ba;
            a_wd = hm_q & ~(EXP'(1) << i_q);
            b_we = 1'b1;
            b_wa = cur_bkt;
            cnt_d = cnt_q - 1'b1;
            rsp_d.occupancy = cnt_q - 1'b1;
          end else begin
            rsp_d.found_value = b_rd.val;
          end
          done_d = 1'b1;
          st_d   = ST_IDLE;
        end else if (i_q == OFF_W'(EXP - 1)) begin
          done_d = 1'b1;
          st_d   = ST_IDLE;
        end else begin
          i_d  = i_q + 1'b1;
          b_ra = cur_bkt + 1'b1;
        end
      end

      ST_IDCHK: begin
        if (a_rd[i_q] && b_rd.vld) begin
          a_we  = 1'b1;
          a_wa  = home_ba;
          a_wd  = a_rd & ~(EXP'(1) << i_q);
          b_we  = 1'b1;
          b_wa  = cur_bkt;
          cnt_d = cnt_q - 1'b1;
          rsp_d.status    = STAT_OK;
          rsp_d.result_id = ID_W'({home_q, ID_HOP_BITS'(i_q)});
          rsp_d.occupancy = cnt_q - 1'b1;
        end
        done_d = 1'b1;
        st_d   = ST_IDLE;
      end

      ST_PROBE: begin
        // Linear probe for a free slot, one read per cycle
        if (!b_rd.vld) begin
          if ((b_q - home_ba) < BA_W'(EXP)) begin
            a_ra = home_ba;
            st_d = ST_INSW;
          end else begin
            s_d  = b_q - BA_W'(EXP - 1);
            a_ra = b_q - BA_W'(EXP - 1);
            st_d = ST_SCAN;
          end
        end else if (b_q == BA_W'(NBKT - 1)) begin
          rsp_d.status = STAT_NO_ROOM;
          done_d = 1'b1;
          st_d   = ST_IDLE;
        end else begin
          b_d  = b_q + 1'b1;
          b_ra = b_q + 1'b1;
        end
      end

      ST_SCAN: begin
        // Look for an entry that may hop into the free slot
        if (lb < LB_W'(hop_dist)) begin
          a_we  = 1'b1;
          a_wa  = s_q;
          a_wd  = (a_rd | (EXP'(1) << hop_dist)) & ~(EXP'(1) << lb);
          src_d = s_q + BA_W'(lb);
          b_ra  = s_q + BA_W'(lb);
          st_d  = ST_MVW1;
        end else if (s_q == b_q - 1'b1) begin
          rsp_d.status = STAT_NO_ROOM;
          done_d = 1'b1;
          st_d   = ST_IDLE;
        end else begin
          s_d  = s_q + 1'b1;
          a_ra = s_q + 1'b1;
        end
      end

      ST_MVW1: begin
        // Move the entry into the free slot
        b_we = 1'b1;
        b_wa = b_q;
        b_wd = '{vld: 1'b1, frag: b_rd.frag, val: b_rd.val};
        st_d = ST_MVW2;
      end

      ST_MVW2: begin
        // Free the source slot and carry on from there
        b_we = 1'b1;
        b_wa = src_q;
        b_d  = src_q;
        if ((src_q - home_ba) < BA_W'(EXP)) begin
          a_ra = home_ba;
          st_d = ST_INSW;
        end else begin
          s_d  = src_q - BA_W'(EXP - 1);
          a_ra = src_q - BA_W'(EXP - 1);
          st_d = ST_SCAN;
        end
      end

      ST_INSW: begin
        a_we  = 1'b1;
        a_wa  = home_ba;
        a_wd  = a_rd | (EXP'(1) << ins_off);
        b_we  = 1'b1;
        b_wa  = b_q;
        b_wd  = '{vld: 1'b1, frag: frag_q, val: val_q};
        cnt_d = cnt_q + 1'b1;
        rsp_d.status    = STAT_OK;
        rsp_d.result_id = ID_W'({home_q, ID_HOP_BITS'(ins_off)});
        rsp_d.occupancy = cnt_q + 1'b1;
        done_d = 1'b1;
        st_d   = ST_IDLE;
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (st_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `HHT_ASSERT_NOW(a_fail_clean, done_o && (rsp_o.status != STAT_OK), (rsp_o.result_id == '0) && (rsp_o.found_value == '0), "failed operation carries data")
  `HHT_ASSERT_NOW(a_cnt_with_rsp, cnt_q != $past(cnt_q), done_o && (rsp_o.occupancy == cnt_q), "count moved without a result")
  `HHT_ASSERT_NOW(a_probe_range, st_q == ST_PROBE, b_q < BA_W'(NBKT), "probe past end of table")
  `HHT_ASSERT_NOW(a_scan_window, st_q == ST_SCAN, (s_q < b_q) && ((b_q - s_q) < BA_W'(EXP)), "swap scan outside neighbourhood")

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hht_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int ITEMS = 1050;
  localparam int TAIL = 100;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t rsp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  in_t  req_i = '0;
  logic busy_o;
  logic done_o;
  out_t rsp_o;

  // Shadow table
  logic [EXP-1:0]    hop_map [NBKT];
  logic [FRAG_W-1:0] frag_mem [NBKT];
  logic [VAL_W-1:0]  val_mem [NBKT];
  bit                occupied [NBKT];
  int                entries;

  out_t   pending_rsp[$];
  in_t    stored_keys[$];
  logic [ID_W-1:0] stored_ids[$];
  int     errors = 0;
  longint cycles = 0;
  bit     no_gaps = 1'b0;

  hopscotch_hash_table_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Work out one operation on the shadow table
  function automatic out_t hash_table_op(in_t r);
    out_t o;
    int home, hop, b, s, h, hop_dist, src, i, k;
    bit moved, ok;
    logic [FRAG_W-1:0] frag;
    o = '0;
    o.status = STAT_MISS;
    home = int'(r.hashcode[HASH_W-1 -: EXP]);
    frag = r.hashcode[FRAG_W-1:0];
    hop = -1;
    if (r.kind == KIND_INS) begin
      b = home;
      while (b < NBKT && occupied[b]) b++;
      ok = (b < NBKT);
      // Swap the free slot back into the neighbourhood
      while (ok && b - home >= EXP) begin
        moved = 1'b0;
        for (s = b - (EXP - 1); s < b && !moved; s++) begin
          h = EXP;
          for (k = EXP - 1; k >= 0; k--) if (hop_map[s][k]) h = k;
          hop_dist = b - s;
          if (h < hop_dist) begin
            hop_map[s][hop_dist] = 1'b1;
            hop_map[s][h] = 1'b0;
            src = s + h;
            frag_mem[b] = frag_mem[src];
            val_mem[b] = val_mem[src];
            occupied[b] = 1'b1;
            occupied[src] = 1'b0;
            b = src;
            moved = 1'b1;
          end
        end
        if (!moved) ok = 1'b0;
      end
      if (!ok) begin
        o.status = STAT_NO_ROOM;
      end else begin
        hop = b - home;
        hop_map[home][hop] = 1'b1;
        frag_mem[b] = frag;
        val_mem[b] = r.value;
        occupied[b] = 1'b1;
        entries++;
        o.status = STAT_OK;
        o.result_id = ID_W'(home * (1 << ID_HOP_BITS) + hop);
      end
    end else if (r.kind == KIND_SRCH || (r.kind == KIND_DEL && !r.by_id)) begin
      for (i = 0; i < EXP && hop < 0; i++) begin
        b = home + i;
        if (hop_map[home][i] && occupied[b] && frag_mem[b] == frag &&
            (r.kind != KIND_DEL || val_mem[b] == r.value)) hop = i;
      end
      if (hop >= 0) begin
        o.status = STAT_OK;
        o.result_id = ID_W'(home * (1 << ID_HOP_BITS) + hop);
        if (r.kind == KIND_SRCH) o.found_value = val_mem[home + hop];
      end
    end else if (r.kind == KIND_DEL) begin
      h = int'(r.pack_id >> ID_HOP_BITS);
      k = int'(r.pack_id[ID_HOP_BITS-1:0]);
      if (h < NHOME && k < EXP) begin
        home = h;
        if (hop_map[home][k] && occupied[home + k]) begin
          hop = k;
          o.status = STAT_OK;
          o.result_id = r.pack_id;
        end
      end
    end
    // Drop the entry on a successful delete
    if (r.kind == KIND_DEL && hop >= 0) begin
      hop_map[home][hop] = 1'b0;
      occupied[home + hop] = 1'b0;
      entries--;
    end
    o.occupancy = CNT_W'(entries);
    return o;
  endfunction

  // Offer one request, hold it until the transfer, then log the expectation
  task automatic send_op(in_t r, bit typed, out_t given);
    out_t p;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
    p = hash_table_op(r);
    pending_rsp.push_back(typed ? given : p);
    if (r.kind == KIND_INS && p.status == STAT_OK) begin
      stored_keys.push_back(r);
      stored_ids.push_back(p.result_id);
      if (stored_keys.size() > 64) void'(stored_keys.pop_front());
      if (stored_ids.size() > 64) void'(stored_ids.pop_front());
    end
  endtask

  // Compare each response with the oldest expectation
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response %p", rsp_o);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_o.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, rsp_o.status);
          errors++;
        end
        if (rsp_o.found_value !== e.found_value) begin
          $error("found_value: expected %h, got %h", e.found_value, rsp_o.found_value);
          errors++;
        end
        if (rsp_o.result_id !== e.result_id) begin
          $error("result_id: expected %0d, got %0d", e.result_id, rsp_o.result_id);
          errors++;
        end
        if (rsp_o.occupancy !== e.occupancy) begin
          $error("occupancy: expected %0d, got %0d", e.occupancy, rsp_o.occupancy);
          errors++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    row_t dir[$];
    row_t row;
    in_t  r;
    int   n, base, pick, home;
    for (int j = 0; j < NBKT; j++) begin
      hop_map[j] = '0;
      occupied[j] = 1'b0;
    end
    entries = 0;

    // Directed rows: misses on an empty table, extremes, duplicates, deletes
    row.typed = 1'b1;
    row.req = '{KIND_SRCH, 32'h0, 32'h0, 1'b0, 14'h0};
    row.rsp = '{STAT_MISS, 32'h0, 14'h0, 9'd0};
    dir.push_back(row);
    row.req = '{KIND_DEL, 32'h0, 32'h0, 1'b1, 14'h3FFF};
    dir.push_back(row);
    row.req = '{KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 14'h3FFF};
    dir.push_back(row);
    row.req = '{KIND_INS, 32'h0, 32'h0, 1'b0, 14'h0};
    row.rsp = '{STAT_OK, 32'h0, 14'd0, 9'd1};
    dir.push_back(row);
    row.req = '{KIND_INS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 14'h3FFF};
    row.rsp = '{STAT_OK, 32'h0, 14'd16320, 9'd2};
    dir.push_back(row);
    row.req = '{KIND_INS, 32'h0, 32'h1234_5678, 1'b0, 14'h0};
    row.rsp = '{STAT_OK, 32'h0, 14'd1, 9'd3};
    dir.push_back(row);
    row.typed = 1'b0;
    row.req = '{KIND_SRCH, 32'h0, 32'h0, 1'b1, 14'h3FFF};
    dir.push_back(row);
    row.req = '{KIND_SRCH, 32'hFFFF_FFFF, 32'h0, 1'b0, 14'h0};
    dir.push_back(row);
    row.req = '{KIND_DEL, 32'h0, 32'h1234_5679, 1'b0, 14'h0};
    dir.push_back(row);
    row.req = '{KIND_DEL, 32'h0, 32'h1234_5678, 1'b0, 14'h0};
    dir.push_back(row);
    row.req = '{KIND_DEL, 32'h0, 32'h0, 1'b1, 14'd16320};
    dir.push_back(row);
    row.req = '{KIND_DEL, 32'h0, 32'h0, 1'b1, 14'd328};
    dir.push_back(row);
    // Fill the last neighbourhood until the insert runs out of room
    for (int j = 0; j < 9; j++) begin
      row.req = '{KIND_INS, {8'hFF, 24'(j)}, 32'(j), 1'b0, 14'h0};
      dir.push_back(row);
    end
    row.req = '{KIND_SRCH, 32'hFF00_0003, 32'h0, 1'b0, 14'h0};
    dir.push_back(row);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir[j]) send_op(dir[j].req, dir[j].typed, dir[j].rsp);

    // Random traffic clustered around a moving home bucket
    base = 0;
    for (int j = 0; j < ITEMS; j++) begin
      if (j % 60 == 0) base = $urandom_range(0, NHOME - 1);
      no_gaps = (j >= ITEMS - TAIL);
      home = base + $urandom_range(0, 11);
      if (home > NHOME - 1 || $urandom_range(0, 9) < 2) home = $urandom_range(0, NHOME - 1);
      r.hashcode = {home[EXP-1:0], 24'($urandom)};
      r.value = $urandom;
      r.by_id = 1'($urandom_range(0, 1));
      r.pack_id = ID_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        r.kind = KIND_INS;
      end else if (pick < 95) begin
        r.kind = (pick < 70) ? KIND_SRCH : KIND_DEL;
        if (r.kind == KIND_DEL) r.by_id = ($urandom_range(0, 2) == 0);
        if (r.kind == KIND_DEL && r.by_id) begin
          if (stored_ids.size() > 0 && $urandom_range(0, 3) != 0)
            r.pack_id = stored_ids[$urandom_range(0, stored_ids.size() - 1)];
        end else if (stored_keys.size() > 0 && $urandom_range(0, 3) != 0) begin
          n = $urandom_range(0, stored_keys.size() - 1);
          r.hashcode = stored_keys[n].hashcode;
          r.value = stored_keys[n].value;
        end
      end else begin
        r.kind = KIND_NONE;
      end
      send_op(r, 1'b0, '0);
    end
    start_i <= 1'b0;

    // Drain outstanding responses
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: hopscotch_hash_table_unit.f
+incdir+sv
sv/hht_pkg.sv
sv/hht_ram.sv
sv/hopscotch_hash_table_unit.sv
tb/sv/testbench.sv
